// ===== hdl/jwsd_pkg.sv =====
package jwsd_pkg;

  // joints per sample and samples per joint ring
  localparam int JOINT_COUNT   = 7;
  localparam int WINDOW_LENGTH = 10;

  // field widths
  localparam int POS_W = 32;
  localparam int THR_W = 16;

  // derived widths
  localparam int HIST_DEPTH = JOINT_COUNT * WINDOW_LENGTH;
  localparam int ADDR_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int JOINT_W    = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int SLOT_W     = $clog2(WINDOW_LENGTH);
  localparam int SEEN_W     = $clog2(WINDOW_LENGTH + 1);
  localparam int IN_W       = JOINT_COUNT * POS_W;
  localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;

  // reset value of the threshold register
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(66);

endpackage

// ===== hdl/jwsd_ram.sv =====
module jwsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 70
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/joint_window_stillness_detector.sv =====
// sequence: a sample beat starts a sweep of the history memory through its single read port,
//   one entry per cycle, then a flush step and a done step that waits for the output register to be
//   free; no new sample is taken until the result has been handed over
// reset: ring pointer, fill count and handshakes clear, threshold returns to 66;
//   the history memory is not cleared, and its entries are compared only after every slot has been written
module joint_window_stillness_detector (
  input  logic                            clk,
  input  logic                            rst,
  // sample stream: joint0_position .. joint6_position, 32 bits each, lowest first
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [jwsd_pkg::IN_BYTES_W-1:0] s_tdata,
  // result stream: bit 0 motion_detected, bits 7:1 zero
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,
  // threshold write channel: motion_threshold
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jwsd_pkg::THR_W-1:0]      cfg_data
);

  import jwsd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FLUSH,
    ST_DONE
  } state_t;

  state_t                    state;
  logic signed [POS_W-1:0]   pos [JOINT_COUNT];
  logic [THR_W-1:0]          motion_threshold;
  logic [SLOT_W-1:0]         write_slot;
  logic [SEEN_W-1:0]         samples_seen;
  logic                      full;
  logic                      moving;
  logic [JOINT_W-1:0]        joint;
  logic [JOINT_W-1:0]        joint_d;
  logic [SLOT_W-1:0]         k;
  logic [ADDR_W-1:0]         addr;
  logic                      rd_valid_d;
  logic                      out_valid;
  logic                      out_moving;

  logic                      ram_we;
  logic [POS_W-1:0]          ram_rdata;
  logic signed [POS_W:0]     diff;
  logic signed [POS_W:0]     thr_pos;
  logic signed [POS_W:0]     thr_neg;
  logic                      hit;

  // handshakes
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {7'b0, out_moving};

  // new sample goes into the ring on the sweep step that lands on the write slot
  assign ram_we = (state == ST_SWEEP) && (k == write_slot);

  jwsd_ram #(
    .WIDTH (POS_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (pos[joint]),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // exact 33-bit deviation against the threshold on both sides
  always_comb begin
    diff    = {pos[joint_d][POS_W-1], pos[joint_d]} -
              {ram_rdata[POS_W-1], ram_rdata};
    thr_pos = $signed({{(POS_W + 1 - THR_W){1'b0}}, motion_threshold});
    thr_neg = -thr_pos;
    hit     = (diff > thr_pos) || (diff < thr_neg);
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      motion_threshold <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      motion_threshold <= cfg_data;
    end
  end

  // sequencer, ring pointer, fill count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      write_slot   <= '0;
      samples_seen <= '0;
      rd_valid_d   <= 1'b0;
      out_valid    <= 1'b0;
      moving       <= 1'b0;
      full         <= 1'b0;
      joint        <= '0;
      joint_d      <= '0;
      k            <= '0;
      addr         <= '0;
    end else begin
      // delayed read tag lines up with the registered read data
      rd_valid_d <= (state == ST_SWEEP) && (k != write_slot);
      joint_d    <= joint;

      // compare the entry read last cycle
      if (rd_valid_d && full && hit) begin
        moving <= 1'b1;
      end

      // result beat taken, unless a new one is loaded below
      if (out_valid && m_tready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            for (int i = 0; i < JOINT_COUNT; i++) begin
              pos[i] <= s_tdata[i*POS_W +: POS_W];
            end
            full   <= (samples_seen == SEEN_W'(WINDOW_LENGTH));
            moving <= 1'b0;
            joint  <= '0;
            k      <= '0;
            addr   <= '0;
            state  <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          addr <= addr + ADDR_W'(1);
          if (k == SLOT_W'(WINDOW_LENGTH - 1)) begin
            k <= '0;
            if (joint == JOINT_W'(JOINT_COUNT - 1)) begin
              state <= ST_FLUSH;
            end else begin
              joint <= joint + JOINT_W'(1);
            end
          end else begin
            k <= k + SLOT_W'(1);
          end
        end
        ST_FLUSH: begin
          // last read is compared this cycle; advance the ring
          if (write_slot == SLOT_W'(WINDOW_LENGTH - 1)) begin
            write_slot <= '0;
          end else begin
            write_slot <= write_slot + SLOT_W'(1);
          end
          if (samples_seen != SEEN_W'(WINDOW_LENGTH)) begin
            samples_seen <= samples_seen + SEEN_W'(1);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hand the result over once the output register is free
          if (!out_valid || m_tready) begin
            out_valid  <= 1'b1;
            out_moving <= moving;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== verif/joint_window_stillness_detector_tb.sv =====
`timescale 1ns / 1ps

module joint_window_stillness_detector_tb;
  import jwsd_pkg::*;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [JOINT_COUNT-1:0][POS_W-1:0] sample_t;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_MOSTLY,
    READY_LONG_STALLS
  } ready_mode_t;

  localparam pos_t POS_MAX     = 32'h7FFF_FFFF;
  localparam pos_t POS_MIN     = 32'h8000_0000;
  localparam pos_t ONE_RAD     = 32'h0001_0000;
  localparam int   CYCLE_LIMIT = 1_500_000;
  localparam int   PHASE_ITEMS = 162;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_BYTES_W-1:0] s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [THR_W-1:0]      cfg_data = '0;

  // samples waiting to be sent, expected motion flags in order
  sample_t pending_samples[$];
  logic    expected_moving[$];
  int      mismatch_count = 0;
  int      cycle_count = 0;

  // predictor state: per-joint rings, ring pointer, fill count, threshold
  pos_t             joint_ring [JOINT_COUNT][WINDOW_LENGTH];
  int               ring_slot = 0;
  int               fill_count = 0;
  logic [THR_W-1:0] threshold_now = THR_RESET;

  joint_window_stillness_detector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // store the sample, then compare it against the full window with 33-bit differences
  function automatic logic predict_motion(sample_t s);
    logic              moving;
    logic signed [32:0] dev;
    moving = 1'b0;
    for (int j = 0; j < JOINT_COUNT; j++) joint_ring[j][ring_slot] = s[j];
    if (fill_count >= WINDOW_LENGTH) begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
        for (int k = 0; k < WINDOW_LENGTH; k++) begin
          dev = $signed({s[j][POS_W-1], s[j]})
              - $signed({joint_ring[j][k][POS_W-1], joint_ring[j][k]});
          if (dev < 0) dev = -dev;
          if (dev > $signed({17'b0, threshold_now})) moving = 1'b1;
        end
      end
    end
    ring_slot = (ring_slot + 1) % WINDOW_LENGTH;
    if (fill_count < WINDOW_LENGTH) fill_count++;
    return moving;
  endfunction

  function automatic sample_t uniform_sample(pos_t p);
    sample_t s;
    for (int j = 0; j < JOINT_COUNT; j++) s[j] = p;
    return s;
  endfunction

  // sample driver: bursts of beats with random gaps in between
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        s_tdata  <= IN_BYTES_W'(pending_samples.pop_front());
        s_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 120) : 0;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result backpressure: one of four ready modes, drawn anew when the current one runs out
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left = 0;
  int          stall_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 400);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
      READY_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          m_tready <= 1'b0;
        end else begin
          m_tready   <= 1'b1;
          stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : 0;
        end
      end
    endcase
  end

  // monitor: predict on sample beats, track threshold writes, check result beats
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_moving.push_back(predict_motion(sample_t'(s_tdata[IN_W-1:0])));
      if (cfg_valid && cfg_ready) threshold_now = cfg_data;
      if (m_tvalid && m_tready) begin
        if (expected_moving.size() == 0) begin
          $display("%0t: result beat with nothing expected, got motion flag %0b",
                   $time, m_tdata[0]);
          mismatch_count++;
        end else begin
          logic exp_moving;
          exp_moving = expected_moving.pop_front();
          if (m_tdata[0] !== exp_moving) begin
            $display("%0t: motion flag mismatch, expected %0b, got %0b",
                     $time, exp_moving, m_tdata[0]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // sender holds off until the block has gone quiet, checked once the edge has settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_samples.size() != 0 || s_tvalid || expected_moving.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] thr);
    @(posedge clk);
    cfg_data  <= thr;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // window fill with extremes, exact threshold, one joint over, full-range difference
  task automatic queue_directed();
    sample_t s;
    pending_samples.push_back(uniform_sample(POS_MAX));
    pending_samples.push_back(uniform_sample(POS_MIN));
    for (int j = 0; j < JOINT_COUNT; j++) s[j] = (j % 2) ? POS_MIN : POS_MAX;
    pending_samples.push_back(s);
    pending_samples.push_back(uniform_sample('0));
    repeat (10) pending_samples.push_back(uniform_sample(ONE_RAD));
    pending_samples.push_back(uniform_sample(ONE_RAD + pos_t'(THR_RESET)));
    s = uniform_sample(ONE_RAD);
    s[JOINT_COUNT-1] = ONE_RAD + pos_t'(THR_RESET) + 1;
    pending_samples.push_back(s);
    repeat (9) pending_samples.push_back(uniform_sample(POS_MAX));
    pending_samples.push_back(uniform_sample(POS_MIN));
  endtask

  // jittered runs around a base per joint: one lead joint near the threshold,
  // the others inside half of it, rare jumps, some edge bases and raw noise
  task automatic queue_motion_phase(input int count, input int thr);
    pos_t    base [JOINT_COUNT];
    int      amp [JOINT_COUNT];
    int      seq_len;
    int      lead;
    int      jit;
    bit      near_edge;
    sample_t s;
    int      made;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) == 0) begin
        for (int j = 0; j < JOINT_COUNT; j++) s[j] = $urandom;
        pending_samples.push_back(s);
        made++;
      end else begin
        seq_len   = $urandom_range(11, 30);
        lead      = $urandom_range(0, JOINT_COUNT - 1);
        near_edge = ($urandom_range(0, 7) == 0);
        for (int j = 0; j < JOINT_COUNT; j++) begin
          if (near_edge)
            base[j] = $urandom_range(0, 1) ? POS_MAX - $urandom_range(0, 2 * thr + 4)
                                           : POS_MIN + $urandom_range(0, 2 * thr + 4);
          else
            base[j] = $urandom;
          if (j == lead) begin
            case ($urandom_range(0, 3))
              0: amp[j] = thr / 2;
              1: amp[j] = thr / 2 + 1;
              2: amp[j] = thr;
              default: amp[j] = $urandom_range(0, thr + 2);
            endcase
          end else begin
            amp[j] = $urandom_range(0, 1) ? thr / 2 : 0;
          end
        end
        for (int i = 0; i < seq_len && made < count; i++) begin
          for (int j = 0; j < JOINT_COUNT; j++) begin
            if ($urandom_range(0, 199) == 0) base[j] = base[j] + $urandom_range(0, 2 * thr + 4);
            jit  = int'($urandom_range(0, 2 * amp[j])) - amp[j];
            s[j] = base[j] + pos_t'(jit);
          end
          pending_samples.push_back(s);
          made++;
        end
      end
    end
  endtask

  // phases: directed at the reset threshold, then random at several thresholds
  initial begin
    int thr_list [7];
    thr_list = '{0, 65535, 1, 66, 200, 0, 0};
    thr_list[5] = $urandom_range(2, 1000);
    thr_list[6] = $urandom_range(0, 65535);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    queue_directed();
    wait_drained();
    foreach (thr_list[p]) begin
      write_threshold(THR_W'(thr_list[p]));
      @(negedge clk);
      queue_motion_phase(PHASE_ITEMS, thr_list[p]);
      wait_drained();
    end
    repeat (100) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
